>>> sv/sbtp_pkg.sv
// shared types, constants and the arctangent table of the beam-to-point converter
package sbtp_pkg;

    // fixed field widths
    localparam int RANGE_W = 16;
    localparam int BEAM_W  = 12;
    localparam int CFG_W   = 16;
    localparam int OUT_W   = 17;

    // parameter defaults
    localparam int INDEX_BITS_DEF = 12;
    localparam int ANGLE_BITS_DEF = 16;

    // cordic datapath
    localparam int CORDIC_STEPS = 24;
    localparam int FRAC_BITS    = 24;
    localparam int XY_W         = 42;
    localparam int Z_W          = 32;
    localparam int PHASE_W      = 32;
    localparam logic [31:0] GAIN_K = 32'h9B74_EDA8;
    localparam logic signed [OUT_W-1:0] OUT_LIMIT = 17'sd65535;

    // register indexes of the configuration port
    localparam logic [1:0] REG_MAX_RANGE   = 2'd0;
    localparam logic [1:0] REG_START_ANGLE = 2'd1;
    localparam logic [1:0] REG_ANGLE_STEP  = 2'd2;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic signed [Z_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'sh2000_0000, 32'sh12E4_051E, 32'sh09FB_385B, 32'sh0511_11D4,
        32'sh028B_0D43, 32'sh0145_D7E1, 32'sh00A2_F61E, 32'sh0051_7C55,
        32'sh0028_BE53, 32'sh0014_5F2F, 32'sh000A_2F98, 32'sh0005_17CC,
        32'sh0002_8BE6, 32'sh0001_45F3, 32'sh0000_A2F9, 32'sh0000_517C,
        32'sh0000_28BE, 32'sh0000_145F, 32'sh0000_0A2F, 32'sh0000_0517,
        32'sh0000_028B, 32'sh0000_0145, 32'sh0000_00A2, 32'sh0000_0051
    };

    // word carried along the rotation stages
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [1:0]             quad;
        logic [BEAM_W-1:0]      beam;
    } sbtp_stage_t;

endpackage

>>> sv/scan_beam_to_point.sv
// top level: laser beam range and index in, cartesian point out
// one beam word may be taken every clock; a kept beam passes 28 register stages (input
// register and step multiply, angle fold and gain multiply, 24 cordic micro-rotations,
// rounding, output register) before it shows on point_valid; beams that are not finite or
// lie beyond max_range_mm give no word; the pipeline only freezes once the output register
// and the skid register behind it both hold words, so a stall at the output raises
// beam_stall at the same clock edge that parks the second word
module scan_beam_to_point #(
    parameter int INDEX_BITS = sbtp_pkg::INDEX_BITS_DEF,
    parameter int ANGLE_BITS = sbtp_pkg::ANGLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration writes
    input  logic                                 cfg_write,
    input  logic [1:0]                           cfg_index,
    input  logic [sbtp_pkg::CFG_W-1:0]           cfg_data,
    // beam words
    input  logic                                 beam_valid,
    output logic                                 beam_stall,
    input  logic [sbtp_pkg::RANGE_W-1:0]         range_mm,
    input  logic                                 range_finite,
    input  logic [sbtp_pkg::BEAM_W-1:0]          beam_number,
    // point words
    output logic                                 point_valid,
    input  logic                                 point_stall,
    output logic signed [sbtp_pkg::OUT_W-1:0]    x_mm,
    output logic signed [sbtp_pkg::OUT_W-1:0]    y_mm,
    output logic [sbtp_pkg::BEAM_W-1:0]          source_beam
);

    // beam index bits that count, never more than the port carries
    localparam int IDX_EFF = (INDEX_BITS < sbtp_pkg::BEAM_W) ? INDEX_BITS : sbtp_pkg::BEAM_W;
    localparam int STEP_PROD_W = sbtp_pkg::CFG_W + sbtp_pkg::BEAM_W + 1;
    localparam int GAIN_PROD_W = sbtp_pkg::RANGE_W + 32;
    localparam int X0_W = GAIN_PROD_W - 8;
    localparam logic signed [sbtp_pkg::XY_W-1:0] ROUND_HALF =
        sbtp_pkg::XY_W'(1) <<< (sbtp_pkg::FRAC_BITS - 1);
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // configuration registers
    logic [sbtp_pkg::CFG_W-1:0]        max_range_reg;
    logic [sbtp_pkg::CFG_W-1:0]        start_angle_reg;
    logic signed [sbtp_pkg::CFG_W-1:0] angle_step_reg;

    // pipeline control
    logic advance;
    logic skid_valid_reg;
    logic out_valid_reg;
    logic out_take;

    // stage 1: keep test, masked index and step times index
    logic [sbtp_pkg::BEAM_W-1:0]      beam_mask;
    logic [sbtp_pkg::BEAM_W-1:0]      beam_masked;
    logic signed [STEP_PROD_W-1:0]    step_prod;
    logic                             keep;
    logic                             s1_valid_reg;
    logic [sbtp_pkg::RANGE_W-1:0]     s1_range_reg;
    logic [sbtp_pkg::BEAM_W-1:0]      s1_beam_reg;
    logic [ANGLE_BITS-1:0]            s1_prod_reg;

    // stage 2: angle fold and gain-scaled start vector
    logic [ANGLE_BITS-1:0]            phase;
    logic [sbtp_pkg::PHASE_W-1:0]     phase_wide;
    logic [GAIN_PROD_W-1:0]           gain_prod;
    sbtp_pkg::sbtp_stage_t            s2_word_next;
    sbtp_pkg::sbtp_stage_t            s2_word_reg;
    logic                             s2_valid_reg;

    // rotation chain
    sbtp_pkg::sbtp_stage_t            chain_word  [sbtp_pkg::CORDIC_STEPS+1];
    logic                             chain_valid [sbtp_pkg::CORDIC_STEPS+1];

    // rounding stage
    sbtp_pkg::sbtp_stage_t            last_word;
    logic signed [sbtp_pkg::XY_W-1:0] x_round;
    logic signed [sbtp_pkg::XY_W-1:0] y_round;
    logic signed [sbtp_pkg::OUT_W-1:0] rx_next;
    logic signed [sbtp_pkg::OUT_W-1:0] ry_next;
    logic signed [sbtp_pkg::OUT_W-1:0] rx_reg;
    logic signed [sbtp_pkg::OUT_W-1:0] ry_reg;
    logic [1:0]                       rq_reg;
    logic [sbtp_pkg::BEAM_W-1:0]      rbeam_reg;
    logic                             rvalid_reg;

    // quadrant restore and output words
    logic signed [sbtp_pkg::OUT_W-1:0] ox_next;
    logic signed [sbtp_pkg::OUT_W-1:0] oy_next;
    logic signed [sbtp_pkg::OUT_W-1:0] x_reg;
    logic signed [sbtp_pkg::OUT_W-1:0] y_reg;
    logic [sbtp_pkg::BEAM_W-1:0]       beam_reg;
    logic signed [sbtp_pkg::OUT_W-1:0] skid_x_reg;
    logic signed [sbtp_pkg::OUT_W-1:0] skid_y_reg;
    logic [sbtp_pkg::BEAM_W-1:0]       skid_beam_reg;

    function automatic logic signed [sbtp_pkg::OUT_W-1:0] saturate(
        input logic signed [sbtp_pkg::XY_W-1:0] v
    );
        logic signed [sbtp_pkg::XY_W-1:0] lim;
        lim = sbtp_pkg::XY_W'(sbtp_pkg::OUT_LIMIT);
        if (v > lim)
            return sbtp_pkg::OUT_LIMIT;
        else if (v < -lim)
            return -sbtp_pkg::OUT_LIMIT;
        else
            return v[sbtp_pkg::OUT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // configuration registers; the user must write them only while the block is idle (not enforced)
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_range_reg   <= '1;
            start_angle_reg <= '0;
            angle_step_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sbtp_pkg::REG_MAX_RANGE:   max_range_reg   <= cfg_data;
                sbtp_pkg::REG_START_ANGLE: start_angle_reg <= cfg_data;
                sbtp_pkg::REG_ANGLE_STEP:  angle_step_reg  <= $signed(cfg_data);
                default:                   ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // flow control: whole pipeline moves unless the skid register is full
    // ------------------------------------------------------------------
    assign advance    = !skid_valid_reg;
    assign beam_stall = skid_valid_reg;
    assign out_take   = out_valid_reg && !point_stall;

    // ------------------------------------------------------------------
    // stage 1
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < sbtp_pkg::BEAM_W; i++)
        begin
            beam_mask[i] = (i < IDX_EFF);
        end
    end

    assign beam_masked = beam_number & beam_mask;
    assign keep        = range_finite && (range_mm <= max_range_reg);
    assign step_prod   = STEP_PROD_W'(angle_step_reg) * $signed({1'b0, beam_masked});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= beam_valid && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_range_reg <= range_mm;
            s1_beam_reg  <= beam_masked;
            s1_prod_reg  <= step_prod[ANGLE_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: angle modulo one turn, eighth-turn offset, quadrant split
    // ------------------------------------------------------------------
    assign phase      = ANGLE_BITS'(start_angle_reg) + s1_prod_reg;
    assign phase_wide = (sbtp_pkg::PHASE_W'(phase) << (sbtp_pkg::PHASE_W - ANGLE_BITS))
                        + 32'h2000_0000;
    assign gain_prod  = GAIN_PROD_W'(s1_range_reg) * GAIN_PROD_W'(sbtp_pkg::GAIN_K);

    always_comb
    begin
        s2_word_next.x    = $signed({{(sbtp_pkg::XY_W-X0_W){1'b0}}, gain_prod[GAIN_PROD_W-1:8]});
        s2_word_next.y    = '0;
        s2_word_next.z    = $signed({2'b00, phase_wide[29:0]}) - 32'sh2000_0000;
        s2_word_next.quad = phase_wide[31:30];
        s2_word_next.beam = s1_beam_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_word_reg <= s2_word_next;
        end
    end

    // ------------------------------------------------------------------
    // cordic chain, one micro-rotation per stage
    // ------------------------------------------------------------------
    assign chain_word[0]  = s2_word_reg;
    assign chain_valid[0] = s2_valid_reg;

    for (genvar g = 0; g < sbtp_pkg::CORDIC_STEPS; g++)
    begin : g_rot
        sbtp_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[g]),
            .in_word   (chain_word[g]),
            .out_valid (chain_valid[g+1]),
            .out_word  (chain_word[g+1])
        );
    end

    // ------------------------------------------------------------------
    // round half up to whole millimetres and clamp
    // ------------------------------------------------------------------
    assign last_word = chain_word[sbtp_pkg::CORDIC_STEPS];
    assign x_round   = (last_word.x + ROUND_HALF) >>> sbtp_pkg::FRAC_BITS;
    assign y_round   = (last_word.y + ROUND_HALF) >>> sbtp_pkg::FRAC_BITS;
    assign rx_next   = saturate(x_round);
    assign ry_next   = saturate(y_round);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rvalid_reg <= chain_valid[sbtp_pkg::CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            rq_reg    <= last_word.quad;
            rbeam_reg <= last_word.beam;
        end
    end

    // ------------------------------------------------------------------
    // put the quarter turns back
    // ------------------------------------------------------------------
    always_comb
    begin
        case (rq_reg)
            QUAD_0:
            begin
                ox_next = rx_reg;
                oy_next = ry_reg;
            end
            QUAD_1:
            begin
                ox_next = -ry_reg;
                oy_next = rx_reg;
            end
            QUAD_2:
            begin
                ox_next = -rx_reg;
                oy_next = -ry_reg;
            end
            QUAD_3:
            begin
                ox_next = ry_reg;
                oy_next = -rx_reg;
            end
            default:
            begin
                ox_next = rx_reg;
                oy_next = ry_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // output register with a skid register behind it
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (rvalid_reg)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                x_reg    <= skid_x_reg;
                y_reg    <= skid_y_reg;
                beam_reg <= skid_beam_reg;
            end
        end
        else if (rvalid_reg)
        begin
            if (!out_valid_reg || out_take)
            begin
                x_reg    <= ox_next;
                y_reg    <= oy_next;
                beam_reg <= rbeam_reg;
            end
            else
            begin
                skid_x_reg    <= ox_next;
                skid_y_reg    <= oy_next;
                skid_beam_reg <= rbeam_reg;
            end
        end
    end

    assign point_valid = out_valid_reg;
    assign x_mm        = x_reg;
    assign y_mm        = y_reg;
    assign source_beam = beam_reg;

`ifndef SYNTHESIS
    // a parked word implies a word in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // a beam that is not finite never enters the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (beam_valid && !beam_stall && !range_finite) |=> !s1_valid_reg)
        else $error("non-finite beam kept");

    // a full skid register freezes the front of the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> (s1_valid_reg == $past(s1_valid_reg)))
        else $error("pipeline moved while frozen");

    // rounded values stay inside the clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> (rx_reg != -17'sd65536 && ry_reg != -17'sd65536))
        else $error("clamp let the most negative code through");
`endif

endmodule

>>> sv/sbtp_cordic_stage.sv
// one registered cordic micro-rotation with a fixed shift
module sbtp_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  sbtp_pkg::sbtp_stage_t in_word,
    output logic                 out_valid,
    output sbtp_pkg::sbtp_stage_t out_word
);

    logic                         valid_reg;
    sbtp_pkg::sbtp_stage_t        word_reg;
    sbtp_pkg::sbtp_stage_t        word_next;
    logic signed [sbtp_pkg::XY_W-1:0] x_shift;
    logic signed [sbtp_pkg::XY_W-1:0] y_shift;

    // arithmetic shift gives the floor of the scaled value
    assign x_shift = $signed(in_word.x) >>> STAGE;
    assign y_shift = $signed(in_word.y) >>> STAGE;

    always_comb
    begin
        word_next = in_word;
        if (!in_word.z[sbtp_pkg::Z_W-1])
        begin
            word_next.x = in_word.x - y_shift;
            word_next.y = in_word.y + x_shift;
            word_next.z = in_word.z - sbtp_pkg::ATAN_TURNS[STAGE];
        end
        else
        begin
            word_next.x = in_word.x + y_shift;
            word_next.y = in_word.y - x_shift;
            word_next.z = in_word.z + sbtp_pkg::ATAN_TURNS[STAGE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> tb/sv/scan_beam_to_point_checker.sv
// point word checker for the beam-to-point converter: predicts every point and compares it
module scan_beam_to_point_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [1:0]                         cfg_index,
    input  logic [sbtp_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               beam_valid,
    input  logic                               beam_stall,
    input  logic [sbtp_pkg::RANGE_W-1:0]       range_mm,
    input  logic                               range_finite,
    input  logic [sbtp_pkg::BEAM_W-1:0]        beam_number,
    input  logic                               point_valid,
    input  logic                               point_stall,
    input  logic signed [sbtp_pkg::OUT_W-1:0]  x_mm,
    input  logic signed [sbtp_pkg::OUT_W-1:0]  y_mm,
    input  logic [sbtp_pkg::BEAM_W-1:0]        source_beam,
    output int                                 mismatches,
    output int                                 points_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     MICRO_ROTATIONS = 24;
    localparam int     FIX_FRAC        = 24;
    localparam longint MM_LIMIT        = 65535;

    // atan(2^-i) in 2^-32 turn units
    localparam longint ROTATION_ATAN [MICRO_ROTATIONS] = '{
        64'sh2000_0000, 64'sh12E4_051E, 64'sh09FB_385B, 64'sh0511_11D4,
        64'sh028B_0D43, 64'sh0145_D7E1, 64'sh00A2_F61E, 64'sh0051_7C55,
        64'sh0028_BE53, 64'sh0014_5F2F, 64'sh000A_2F98, 64'sh0005_17CC,
        64'sh0002_8BE6, 64'sh0001_45F3, 64'sh0000_A2F9, 64'sh0000_517C,
        64'sh0000_28BE, 64'sh0000_145F, 64'sh0000_0A2F, 64'sh0000_0517,
        64'sh0000_028B, 64'sh0000_0145, 64'sh0000_00A2, 64'sh0000_0051
    };

    typedef struct packed {
        logic signed [sbtp_pkg::OUT_W-1:0] x;
        logic signed [sbtp_pkg::OUT_W-1:0] y;
        logic [sbtp_pkg::BEAM_W-1:0]       beam;
    } point_word_t;

    point_word_t                  expected_points [$];
    logic [sbtp_pkg::CFG_W-1:0]   max_range_q;
    logic [sbtp_pkg::CFG_W-1:0]   start_angle_q;
    logic [sbtp_pkg::CFG_W-1:0]   angle_step_q;
    int                           miss_count = 0;

    function automatic longint round_mm(input longint v);
        longint r;
        r = (v + 64'sh80_0000) >>> FIX_FRAC;
        if (r > MM_LIMIT)
            r = MM_LIMIT;
        if (r < -MM_LIMIT)
            r = -MM_LIMIT;
        return r;
    endfunction

    function automatic point_word_t predict_point(
        input logic [sbtp_pkg::RANGE_W-1:0] range,
        input logic [sbtp_pkg::BEAM_W-1:0]  beam
    );
        logic [15:0]  phase;
        logic [31:0]  turn;
        logic [1:0]   quad;
        logic [63:0]  scaled;
        longint       x, y, z, xs, ys, rx, ry, ox, oy;
        point_word_t  p;
        // angle wraps modulo one turn, step sign does not matter for the low bits
        phase  = start_angle_q + angle_step_q * {4'b0000, beam};
        turn   = {phase, 16'h0000} + 32'h2000_0000;
        quad   = turn[31:30];
        z      = longint'(turn[29:0]) - 64'sh2000_0000;
        scaled = 64'(range) * 64'h9B74_EDA8;
        x      = longint'(scaled >> 8);
        y      = 0;
        for (int i = 0; i < MICRO_ROTATIONS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ROTATION_ATAN[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ROTATION_ATAN[i];
            end
        end
        rx = round_mm(x);
        ry = round_mm(y);
        case (quad)
            2'd0:    begin ox = rx;  oy = ry;  end
            2'd1:    begin ox = -ry; oy = rx;  end
            2'd2:    begin ox = -rx; oy = -ry; end
            default: begin ox = ry;  oy = -rx; end
        endcase
        p.x    = ox[sbtp_pkg::OUT_W-1:0];
        p.y    = oy[sbtp_pkg::OUT_W-1:0];
        p.beam = beam;
        return p;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] point mismatch: %s", $time, what);
        miss_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_words
        point_word_t want;
        if (!rst_n)
        begin
            max_range_q   = 16'hFFFF;
            start_angle_q = '0;
            angle_step_q  = '0;
            expected_points.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    sbtp_pkg::REG_MAX_RANGE:   max_range_q   = cfg_data;
                    sbtp_pkg::REG_START_ANGLE: start_angle_q = cfg_data;
                    sbtp_pkg::REG_ANGLE_STEP:  angle_step_q  = cfg_data;
                    default:                   ;
                endcase
            end
            if (point_valid && !point_stall)
            begin
                if (expected_points.size() == 0)
                    flag_mismatch($sformatf("unexpected word, beam %0d", source_beam));
                else
                begin
                    want = expected_points.pop_front();
                    if (x_mm !== want.x)
                        flag_mismatch($sformatf("beam %0d x %0d, want %0d",
                                                want.beam, x_mm, want.x));
                    if (y_mm !== want.y)
                        flag_mismatch($sformatf("beam %0d y %0d, want %0d",
                                                want.beam, y_mm, want.y));
                    if (source_beam !== want.beam)
                        flag_mismatch($sformatf("source beam %0d, want %0d",
                                                source_beam, want.beam));
                end
            end
            if (beam_valid && !beam_stall && range_finite && range_mm <= max_range_q)
                expected_points.push_back(predict_point(range_mm, beam_number));
        end
        points_pending <= expected_points.size();
        mismatches     <= miss_count;
    end

endmodule

>>> tb/sv/scan_beam_to_point_tb.sv
// testbench top of the beam-to-point converter: clock, reset, beam stimulus and verdict
module scan_beam_to_point_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // longer than a kept beam takes to pass the register chain of the converter, so this clears
    // the chain
    localparam int PIPE_CLEAR     = 40;
    // long output hold-off, well past the pipeline depth plus the skid register
    localparam int HOLD_CYCLES    = 150;
    // clocks with no word moving on either side before the run is called hung
    localparam int WATCHDOG_LIMIT = 2000;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                cfg_write;
    logic [1:0]                          cfg_index;
    logic [sbtp_pkg::CFG_W-1:0]          cfg_data;
    logic                                beam_valid;
    logic                                beam_stall;
    logic [sbtp_pkg::RANGE_W-1:0]        range_mm;
    logic                                range_finite;
    logic [sbtp_pkg::BEAM_W-1:0]         beam_number;
    logic                                point_valid;
    logic                                point_stall;
    logic signed [sbtp_pkg::OUT_W-1:0]   x_mm;
    logic signed [sbtp_pkg::OUT_W-1:0]   y_mm;
    logic [sbtp_pkg::BEAM_W-1:0]         source_beam;

    int                                  mismatches;
    int                                  points_pending;
    int                                  quiet_cycles = 0;

    // stimulus knobs: sender gaps and the range limit are local to the stimulus process, the
    // receive gaps and the long hold are picked up by the output side
    bit                                  send_gaps = 1'b1;
    logic                                recv_gaps = 1'b1;
    logic                                long_hold = 1'b0;
    logic [sbtp_pkg::CFG_W-1:0]          range_limit = 16'hFFFF;

    always #1 clk = ~clk;

    scan_beam_to_point u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .beam_valid   (beam_valid),
        .beam_stall   (beam_stall),
        .range_mm     (range_mm),
        .range_finite (range_finite),
        .beam_number  (beam_number),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .x_mm         (x_mm),
        .y_mm         (y_mm),
        .source_beam  (source_beam)
    );

    scan_beam_to_point_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .beam_valid     (beam_valid),
        .beam_stall     (beam_stall),
        .range_mm       (range_mm),
        .range_finite   (range_finite),
        .beam_number    (beam_number),
        .point_valid    (point_valid),
        .point_stall    (point_stall),
        .x_mm           (x_mm),
        .y_mm           (y_mm),
        .source_beam    (source_beam),
        .mismatches     (mismatches),
        .points_pending (points_pending)
    );

    // offer one beam word and return at the edge where it is taken; valid stays high
    // afterwards so back-to-back words need no drop in between
    task automatic send_beam(input logic [sbtp_pkg::RANGE_W-1:0] r, input logic f,
                             input logic [sbtp_pkg::BEAM_W-1:0] b);
        int gap;
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            beam_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beam_valid   <= 1'b1;
        range_mm     <= r;
        range_finite <= f;
        beam_number  <= b;
        @(posedge clk);
        while (beam_stall)
            @(posedge clk);
    endtask

    // stop offering, wait until every predicted point has come out, then give the
    // chain some extra clocks so that a stray word would still be seen
    task automatic drain_points();
        beam_valid <= 1'b0;
        @(posedge clk);
        while (points_pending != 0)
            @(posedge clk);
        repeat (PIPE_CLEAR) @(posedge clk);
    endtask

    // write all three registers on consecutive clocks, only while the block is idle
    task automatic load_scan_config(input logic [sbtp_pkg::CFG_W-1:0] max_mm,
                                    input logic [sbtp_pkg::CFG_W-1:0] start,
                                    input logic [sbtp_pkg::CFG_W-1:0] step);
        cfg_write <= 1'b1;
        cfg_index <= sbtp_pkg::REG_MAX_RANGE;
        cfg_data  <= max_mm;
        @(posedge clk);
        cfg_index <= sbtp_pkg::REG_START_ANGLE;
        cfg_data  <= start;
        @(posedge clk);
        cfg_index <= sbtp_pkg::REG_ANGLE_STEP;
        cfg_data  <= step;
        @(posedge clk);
        cfg_write   <= 1'b0;
        range_limit = max_mm;
    endtask

    // random beams, mostly kept: ranges mostly lie within the current maximum so that
    // even a tiny limit still lets points through, with the edges of the limit mixed in
    task automatic random_beams(input int count);
        logic [sbtp_pkg::RANGE_W-1:0] r;
        logic                         f;
        logic [sbtp_pkg::BEAM_W-1:0]  b;
        int                           pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 13)
                r = 16'($urandom_range(0, range_limit));
            else if (pick < 16)
                r = 16'($urandom);
            else if (pick == 16)
                r = '0;
            else if (pick == 17)
                r = range_limit;
            else if (pick == 18)
                r = range_limit + 16'd1;
            else
                r = 16'hFFFF;
            f = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 15) == 0)
                b = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            else
                b = 12'($urandom);
            send_beam(r, f, b);
        end
    endtask

    // output side: short random stall bursts, or one long hold-off on request so the
    // chain and the skid register fill and the input side backs up
    initial
    begin
        point_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                point_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                point_stall <= 1'b0;
                while (long_hold)
                    @(posedge clk);
            end
            else if (recv_gaps && $urandom_range(0, 5) == 0)
            begin
                point_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                point_stall <= 1'b0;
            end
        end
    end

    // watchdog: any clock with a word taken on either side resets the count
    always @(posedge clk)
    begin
        if ((beam_valid && !beam_stall) || (point_valid && !point_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("scan_beam_to_point_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= sbtp_pkg::REG_MAX_RANGE;
        cfg_data     <= '0;
        beam_valid   <= 1'b0;
        range_mm     <= '0;
        range_finite <= 1'b0;
        beam_number  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: angle zero for every beam, nothing beyond full range
        send_beam(16'd0,     1'b1, 12'd0);
        send_beam(16'hFFFF,  1'b1, 12'hFFF);
        send_beam(16'd1234,  1'b0, 12'd7);
        send_beam(16'hFFFF,  1'b0, 12'd0);
        send_beam(16'd1,     1'b1, 12'd1);

        // sixteenth-turn steps: beams 0..15 walk every octant and quadrant boundary
        drain_points();
        load_scan_config(16'd1000, 16'h0000, 16'h1000);
        for (int k = 0; k < 16; k++)
            send_beam(16'd1000, 1'b1, 12'(k));
        send_beam(16'd1001, 1'b1, 12'd3);
        send_beam(16'd1000, 1'b1, 12'hFFF);

        // zero maximum keeps only zero-range beams; largest negative step
        drain_points();
        load_scan_config(16'd0, 16'hFFFF, 16'h8000);
        send_beam(16'd0, 1'b1, 12'd5);
        send_beam(16'd1, 1'b1, 12'd6);
        send_beam(16'd0, 1'b0, 12'd9);

        // full range, random start and step
        drain_points();
        load_scan_config(16'hFFFF, 16'($urandom), 16'($urandom));
        random_beams(180);

        // smallest nonzero maximum, largest start and positive step
        drain_points();
        load_scan_config(16'd1, 16'hFFFF, 16'h7FFF);
        random_beams(120);

        // random settings with one mid-phase pause until the block is empty
        drain_points();
        load_scan_config(16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom));
        random_beams(80);
        drain_points();
        random_beams(80);

        // long output hold-off while beams keep coming
        drain_points();
        load_scan_config(16'd40000, 16'($urandom), 16'h0001);
        long_hold <= 1'b1;
        random_beams(100);
        long_hold <= 1'b0;
        random_beams(70);

        // last stretch flat out, no gaps on either side
        drain_points();
        send_gaps = 1'b0;
        recv_gaps <= 1'b0;
        load_scan_config(16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom));
        random_beams(200);

        drain_points();
        if (mismatches == 0 && points_pending == 0)
            $display("scan_beam_to_point_tb: PASS");
        else
            $display("scan_beam_to_point_tb: FAIL");
        $finish;
    end

endmodule
